// ===== rtl/fprc_pkg.sv =====
`default_nettype none

package fprc_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int ASIN_ITER_DEF   = 16;

	localparam int ANGLE_W   = 15;
	localparam int ANGLE_MAX = 23040;
	localparam int QUAT_W    = 16;
	localparam int POT_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 15;
	localparam int OUT_CNT_W = 16;

	// Serial product width, square-root radicand and root widths.
	localparam int PROD_W = 34;
	localparam int RAD_W  = 30;
	localparam int ROOT_W = 15;

	// CORDIC datapath widths.
	localparam int CORD_XY_W = 26;
	localparam int CORD_Z_W  = 25;
	localparam int ATAN_W    = 23;
	localparam int ATAN_IDX_W = 5;

	// Constant divider widths.
	localparam int DIVD_W = 30;
	localparam int DIVS_W = 10;

	// Request codes.
	localparam logic [1:0] REQ_SAMPLE  = 2'd0;
	localparam logic [1:0] REQ_ZERO    = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;
	localparam logic [1:0] REQ_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMU_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMU_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POT_HIGH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POT_LOW     = 3'd4;

	// Arctangent of 2^-i in degrees, Q16.
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		unique case (idx)
			5'd0:  v = 23'd2949120;
			5'd1:  v = 23'd1740967;
			5'd2:  v = 23'd919879;
			5'd3:  v = 23'd466945;
			5'd4:  v = 23'd234379;
			5'd5:  v = 23'd117304;
			5'd6:  v = 23'd58666;
			5'd7:  v = 23'd29335;
			5'd8:  v = 23'd14668;
			5'd9:  v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			5'd20: v = 23'd4;
			5'd21: v = 23'd2;
			5'd22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fprc_smul.sv =====
`default_nettype none

// Bit-serial a*b - c*d, multiplier bits taken MSB first.
module fprc_smul (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]     op_a,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]     op_b,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]     op_c,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]     op_d,
	output logic                                        done,
	output logic signed [fprc_pkg::PROD_W-1:0]          prod
);

	localparam int W  = fprc_pkg::QUAT_W;
	localparam int PW = fprc_pkg::PROD_W;
	localparam int CW = $clog2(W);

	logic signed [W-1:0]  a_q, c_q;
	logic [W-1:0]         b_q, d_q;
	logic signed [PW-1:0] acc_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;
	logic signed [PW-1:0] ta, tc, sum;

	always_comb begin
		ta  = b_q[W-1] ? PW'(a_q) : '0;
		tc  = d_q[W-1] ? PW'(c_q) : '0;
		sum = ta - tc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(W-1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			c_q   <= op_c;
			d_q   <= op_d;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q <= b_q << 1;
			d_q <= d_q << 1;
			// The sign bit of the multiplier carries negative weight.
			if (cnt_q == '0) begin
				acc_q <= -sum;
			end else begin
				acc_q <= (acc_q <<< 1) + sum;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// ===== rtl/fprc_isqrt.sv =====
`default_nettype none

// Floor square root, one radix-4 digit of the radicand per cycle.
module fprc_isqrt (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [fprc_pkg::RAD_W-1:0]      radicand,
	output logic                                 done,
	output logic [fprc_pkg::ROOT_W-1:0]          root
);

	localparam int RW = fprc_pkg::RAD_W;
	localparam int OW = fprc_pkg::ROOT_W;
	localparam int MW = OW + 3;
	localparam int CW = $clog2(OW);

	logic [RW-1:0] rad_q;
	logic [OW-1:0] root_q;
	logic [MW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [MW-1:0] rem_sh, trial;
	logic          fits;

	always_comb begin
		rem_sh = {rem_q[MW-3:0], rad_q[RW-1:RW-2]};
		trial  = MW'({root_q, 2'b01});
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(OW-1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(OW-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[OW-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== rtl/fprc_cordic.sv =====
`default_nettype none

// Iterative CORDIC in vectoring mode; one rotation per cycle.
module fprc_cordic #(
	parameter int ITER = fprc_pkg::ASIN_ITER_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [fprc_pkg::ROOT_W-1:0]          cos_in,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]   sin_in,
	output logic                                      done,
	output logic signed [fprc_pkg::CORD_Z_W-1:0]      angle
);

	localparam int XW = fprc_pkg::CORD_XY_W;
	localparam int ZW = fprc_pkg::CORD_Z_W;
	localparam int CW = (ITER > 1) ? $clog2(ITER) : 1;

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;
	logic signed [XW-1:0] dx, dy;
	logic signed [ZW-1:0] at;

	always_comb begin
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		at = ZW'($signed({1'b0, fprc_pkg::atan_q16(fprc_pkg::ATAN_IDX_W'(cnt_q))}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(ITER-1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ITER-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= XW'($signed({1'b0, cos_in, 8'b0}));
			y_q <= XW'($signed({sin_in, 8'b0}));
			z_q <= '0;
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

`default_nettype wire

// ===== rtl/fprc_cdiv.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, small unsigned divisor.
module fprc_cdiv (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [fprc_pkg::DIVD_W-1:0]    dividend,
	input  wire logic [fprc_pkg::DIVS_W-1:0]    divisor,
	output logic                                done,
	output logic [fprc_pkg::DIVD_W-1:0]         quotient
);

	localparam int DW = fprc_pkg::DIVD_W;
	localparam int SW = fprc_pkg::DIVS_W;
	localparam int CW = $clog2(DW);

	logic [DW-1:0] quo_q;
	logic [SW-1:0] dsr_q;
	logic [SW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [SW:0]   rem_sh;
	logic          fits;

	always_comb begin
		rem_sh = {rem_q[SW-1:0], quo_q[DW-1]};
		fits   = rem_sh >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(DW-1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The dividend shifts out of quo_q while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dsr_q} : rem_sh;
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/finger_pitch_repetition_counter.sv =====
// Path: an IMU sample passes from accept to result through the serial multiplier (twice),
// the square root, the CORDIC, the serial divider and the sequencer steps; a pot sample
// that divides uses the divider only, and other requests go straight to the result step.
// Throughput: one request at a time; the next is taken the cycle after the result is
// registered, and a stalled earlier result holds the sequencer in its result step.
// Reset: asynchronous, active low; clears filter, zero, count, up flag, loads thresholds.
`default_nettype none

module finger_pitch_repetition_counter #(
	parameter int COUNT_WIDTH     = fprc_pkg::COUNT_WIDTH_DEF,
	parameter int ASIN_ITERATIONS = fprc_pkg::ASIN_ITER_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Sample request channel.
	input  wire logic                                   sample_valid,
	output logic                                        sample_stall,
	input  wire logic [1:0]                             req_type,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]     quat_real,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]     quat_i,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]     quat_j,
	input  wire logic signed [fprc_pkg::QUAT_W-1:0]     quat_k,
	input  wire logic [fprc_pkg::POT_W-1:0]             pot_sample,
	// Result channel.
	output logic                                        result_valid,
	input  wire logic                                   result_stall,
	output logic [fprc_pkg::ANGLE_W-1:0]                finger_angle,
	output logic                                        finger_up,
	output logic [fprc_pkg::OUT_CNT_W-1:0]              move_count,
	output logic                                        move_done,
	// Configuration write channel.
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [fprc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [fprc_pkg::CFG_DAT_W-1:0]         cfg_data
);

	localparam int AW = fprc_pkg::ANGLE_W;
	localparam int QW = fprc_pkg::QUAT_W;

	// The sequencer walks an IMU request through multiply, square, root,
	// arcsine and the filter divide. Pot samples above the zero go straight to the divider.
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_PREP  = 10'b00_0000_0010,
		ST_MUL   = 10'b00_0000_0100,
		ST_SQS   = 10'b00_0000_1000,
		ST_SQ    = 10'b00_0001_0000,
		ST_SQRT  = 10'b00_0010_0000,
		ST_CORD  = 10'b00_0100_0000,
		ST_SMS   = 10'b00_1000_0000,
		ST_DIV   = 10'b01_0000_0000,
		ST_FIN   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic         mode_q;
	logic [AW-1:0] imu_hi_q, imu_lo_q, pot_hi_q, pot_lo_q;

	// Architectural state.
	logic signed [QW-1:0]   smooth_q;
	logic signed [QW-1:0]   zero_q;
	logic                   up_q;
	logic [COUNT_WIDTH-1:0] total_q;

	// Captured request.
	logic [1:0]                     req_q;
	logic signed [QW-1:0]           w_q, i_q, j_q, k_q;
	logic [fprc_pkg::POT_W-1:0]     pot_q;

	// Intermediate results.
	logic signed [QW-1:0]   sin_q;
	logic signed [QW-1:0]   pitch_q;
	logic [AW-1:0]          pot_ang_q;

	// Result register.
	logic                   res_valid_q;
	logic [AW-1:0]          res_angle_q;
	logic                   res_up_q;
	logic [COUNT_WIDTH-1:0] res_total_q;
	logic                   res_done_q;

	// Unit handshakes.
	logic                                   mul_start, mul_done;
	logic signed [QW-1:0]                   mul_a, mul_b, mul_c, mul_d;
	logic signed [fprc_pkg::PROD_W-1:0]     mul_prod;
	logic                                   sqrt_start, sqrt_done;
	logic [fprc_pkg::RAD_W-1:0]             sqrt_rad;
	logic [fprc_pkg::ROOT_W-1:0]            sqrt_root;
	logic                                   cord_start, cord_done;
	logic signed [fprc_pkg::CORD_Z_W-1:0]   cord_z;
	logic                                   div_start, div_done;
	logic [fprc_pkg::DIVD_W-1:0]            div_dividend;
	logic [fprc_pkg::DIVS_W-1:0]            div_divisor;
	logic [fprc_pkg::DIVD_W-1:0]            div_quo;

	logic accept, out_free, is_sample;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign out_free     = !res_valid_q || !result_stall;
	assign is_sample    = (req_q == fprc_pkg::REQ_SAMPLE) || (req_q == fprc_pkg::REQ_ZERO);
	assign cfg_ready    = 1'b1;

	// The user must send configuration writes only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			imu_hi_q <= AW'(11520);
			imu_lo_q <= AW'(2560);
			pot_hi_q <= AW'(11520);
			pot_lo_q <= AW'(2560);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fprc_pkg::REG_SENSOR_MODE: mode_q   <= cfg_data[0];
				fprc_pkg::REG_IMU_HIGH:    imu_hi_q <= cfg_data;
				fprc_pkg::REG_IMU_LOW:     imu_lo_q <= cfg_data;
				fprc_pkg::REG_POT_HIGH:    pot_hi_q <= cfg_data;
				fprc_pkg::REG_POT_LOW:     pot_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pot path: relative reading, then the scaled dividend r*23040 built from
	// shifted copies (23040 = 2^14 + 2^12 + 2^11 + 2^9).
	logic signed [QW:0]          pot_rel;
	logic [fprc_pkg::DIVD_W-1:0] pot_r, pot_scaled;

	always_comb begin
		pot_rel    = $signed({7'b0, pot_q}) - (QW+1)'(zero_q);
		pot_r      = fprc_pkg::DIVD_W'(pot_rel[QW-1:0]);
		pot_scaled = (pot_r << 14) + (pot_r << 12) + (pot_r << 11) + (pot_r << 9);
	end

	// Sine clamp: floor(p / 2^13) limited to one in Q14.
	logic signed [fprc_pkg::PROD_W-14:0] sin_raw;
	logic signed [QW-1:0]                sin_clamped;

	always_comb begin
		sin_raw = mul_prod[fprc_pkg::PROD_W-1:13];
		if (sin_raw > 16384) begin
			sin_clamped = QW'(16384);
		end else if (sin_raw < -16384) begin
			sin_clamped = -QW'(16384);
		end else begin
			sin_clamped = QW'(sin_raw);
		end
	end

	// Pitch rounding to Q8.8 degrees and clamp to plus or minus ninety.
	logic signed [fprc_pkg::CORD_Z_W-1:0] z_rnd;
	logic signed [fprc_pkg::CORD_Z_W-9:0] pitch_raw;
	logic signed [QW-1:0]                 pitch_clamped;

	always_comb begin
		z_rnd     = cord_z + fprc_pkg::CORD_Z_W'(128);
		pitch_raw = z_rnd[fprc_pkg::CORD_Z_W-1:8];
		if (pitch_raw > fprc_pkg::ANGLE_MAX) begin
			pitch_clamped = QW'(fprc_pkg::ANGLE_MAX);
		end else if (pitch_raw < -fprc_pkg::ANGLE_MAX) begin
			pitch_clamped = -QW'(fprc_pkg::ANGLE_MAX);
		end else begin
			pitch_clamped = QW'(pitch_raw);
		end
	end

	// The filter computes floor((2*old + 8*pitch + 5) / 10). A bias of
	// 240000, itself a multiple of ten, keeps the dividend positive and is
	// taken back off the quotient as 24000.
	logic signed [QW-1:0] smooth_old;
	logic signed [31:0]   smooth_num;

	always_comb begin
		smooth_old = (smooth_q == '0) ? pitch_q : smooth_q;
		smooth_num = (32'(smooth_old) <<< 1) + (32'(pitch_q) <<< 3) + 32'sd240005;
	end

	// Unit starts and operand selection.
	always_comb begin
		mul_start  = 1'b0;
		sqrt_start = 1'b0;
		cord_start = 1'b0;
		div_start  = 1'b0;
		mul_a = w_q;
		mul_b = j_q;
		mul_c = k_q;
		mul_d = i_q;
		div_dividend = pot_scaled;
		div_divisor  = fprc_pkg::DIVS_W'(1023);
		sqrt_rad   = fprc_pkg::RAD_W'(34'sd268435456 - mul_prod);
		unique case (state_q)
			ST_PREP: begin
				if (is_sample && !mode_q) begin
					mul_start = 1'b1;
				end else if ((req_q == fprc_pkg::REQ_SAMPLE) && mode_q && (pot_rel > 0)) begin
					div_start = 1'b1;
				end
			end
			ST_SQS: begin
				mul_start = 1'b1;
				mul_a = sin_q;
				mul_b = sin_q;
				mul_c = '0;
				mul_d = '0;
			end
			ST_SQ:   sqrt_start = mul_done;
			ST_SQRT: cord_start = sqrt_done;
			ST_SMS: begin
				div_start    = 1'b1;
				div_dividend = fprc_pkg::DIVD_W'(smooth_num);
				div_divisor  = fprc_pkg::DIVS_W'(10);
			end
			default: ;
		endcase
	end

	// Commit values for the result step.
	logic signed [QW-1:0]   zero_next;
	logic signed [QW:0]     imu_rel;
	logic [AW-1:0]          angle_next, hi_sel, lo_sel;
	logic                   up_next, done_next;
	logic [COUNT_WIDTH-1:0] total_next;

	always_comb begin
		zero_next = zero_q;
		if (req_q == fprc_pkg::REQ_ZERO) begin
			zero_next = mode_q ? QW'({6'b0, pot_q}) : smooth_q;
		end
		imu_rel = (QW+1)'(smooth_q) - (QW+1)'(zero_next);
		if (!is_sample) begin
			angle_next = '0;
		end else if (mode_q) begin
			angle_next = pot_ang_q;
		end else if (imu_rel < 0) begin
			angle_next = '0;
		end else if (imu_rel > fprc_pkg::ANGLE_MAX) begin
			angle_next = AW'(fprc_pkg::ANGLE_MAX);
		end else begin
			angle_next = AW'(imu_rel);
		end
		hi_sel     = mode_q ? pot_hi_q : imu_hi_q;
		lo_sel     = mode_q ? pot_lo_q : imu_lo_q;
		up_next    = up_q;
		total_next = total_q;
		done_next  = 1'b0;
		priority if (req_q == fprc_pkg::REQ_CLEAR) begin
			up_next    = 1'b0;
			total_next = '0;
		end else if (req_q == fprc_pkg::REQ_SAMPLE) begin
			if (!up_q && (angle_next > hi_sel)) begin
				up_next = 1'b1;
			end else if (up_q && (angle_next < lo_sel)) begin
				up_next   = 1'b0;
				done_next = 1'b1;
				// The count holds at its top value; the movement still shows.
				if (total_q != {COUNT_WIDTH{1'b1}}) begin
					total_next = total_q + 1'b1;
				end
			end
		end else begin
		end
	end

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			smooth_q    <= '0;
			zero_q      <= '0;
			up_q        <= 1'b0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one leaving in the same cycle.
			if ((state_q == ST_FIN) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (mul_start) begin
						state_q <= ST_MUL;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MUL:  if (mul_done)  state_q <= ST_SQS;
				ST_SQS:  state_q <= ST_SQ;
				ST_SQ:   if (mul_done)  state_q <= ST_SQRT;
				ST_SQRT: if (sqrt_done) state_q <= ST_CORD;
				ST_CORD: if (cord_done) state_q <= ST_SMS;
				ST_SMS:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
						if (!mode_q) begin
							smooth_q <= QW'($signed({1'b0, div_quo[QW-1:0]})
								- (QW+1)'(24000));
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						zero_q      <= zero_next;
						up_q        <= up_next;
						total_q     <= total_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			w_q   <= quat_real;
			i_q   <= quat_i;
			j_q   <= quat_j;
			k_q   <= quat_k;
			pot_q <= pot_sample;
		end
		if ((state_q == ST_MUL) && mul_done) begin
			sin_q <= sin_clamped;
		end
		if ((state_q == ST_CORD) && cord_done) begin
			pitch_q <= pitch_clamped;
		end
		// A pot reading at or below the zero, and any zero capture in pot
		// mode, gives an angle of zero without a divide.
		if (state_q == ST_PREP) begin
			pot_ang_q <= '0;
		end
		if ((state_q == ST_DIV) && div_done) begin
			pot_ang_q <= (div_quo > fprc_pkg::DIVD_W'(fprc_pkg::ANGLE_MAX))
				? AW'(fprc_pkg::ANGLE_MAX) : div_quo[AW-1:0];
		end
		if ((state_q == ST_FIN) && out_free) begin
			res_angle_q <= angle_next;
			res_up_q    <= up_next;
			res_total_q <= total_next;
			res_done_q  <= done_next;
		end
	end

	fprc_smul u_smul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_start),
		.op_a     (mul_a),
		.op_b     (mul_b),
		.op_c     (mul_c),
		.op_d     (mul_d),
		.done     (mul_done),
		.prod     (mul_prod)
	);

	fprc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_rad),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	fprc_cordic #(
		.ITER     (ASIN_ITERATIONS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cord_start),
		.cos_in   (sqrt_root),
		.sin_in   (sin_q),
		.done     (cord_done),
		.angle    (cord_z)
	);

	fprc_cdiv u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign result_valid = res_valid_q;
	assign finger_angle = res_angle_q;
	assign finger_up    = res_up_q;
	assign move_count   = fprc_pkg::OUT_CNT_W'(res_total_q);
	assign move_done    = res_done_q;

	// A completed movement always leaves the finger down.
	a_done_down: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && move_done) |-> !finger_up)
		else $error("movement reported with finger still up");

	// The reported angle never leaves the 0..90 degree range.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (finger_angle <= AW'(fprc_pkg::ANGLE_MAX)))
		else $error("angle out of range");

	// A new result is only loaded from the result step of the sequencer.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the result step");

	// The up flag only changes when a request completes.
	a_up_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(up_q != $past(up_q)) |-> $past(state_q == ST_FIN))
		else $error("up flag changed mid request");

endmodule

`default_nettype wire

// ===== tb/finger_pitch_repetition_counter_test.sv =====
`default_nettype none

module finger_pitch_repetition_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	// One request on the sample channel.
	typedef struct {
		logic [1:0]         req;
		logic signed [15:0] w;
		logic signed [15:0] qi;
		logic signed [15:0] qj;
		logic signed [15:0] qk;
		logic [9:0]         pot;
	} sample_req_t;

	// One item on the result channel.
	typedef struct {
		logic [14:0] angle;
		logic        up;
		logic [15:0] count;
		logic        done;
	} finger_result_t;

	// Arctangent of 2^-i in degrees, Q16, used by the pitch predictor.
	localparam longint ARCTAN_Q16 [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};
	localparam int CORDIC_STEPS = fprc_pkg::ASIN_ITER_DEF;
	localparam longint COUNT_SAT = (64'd1 << fprc_pkg::COUNT_WIDTH_DEF) - 1;
	localparam int STALL_LIMIT = 20000;
	localparam real PI = 3.14159265358979;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [1:0] req_type = fprc_pkg::REQ_SAMPLE;
	logic signed [15:0] quat_real = '0;
	logic signed [15:0] quat_i = '0;
	logic signed [15:0] quat_j = '0;
	logic signed [15:0] quat_k = '0;
	logic [9:0] pot_sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [14:0] finger_angle;
	logic finger_up;
	logic [15:0] move_count;
	logic move_done;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = fprc_pkg::REG_SENSOR_MODE;
	logic [14:0] cfg_data = '0;

	// Sender and receiver idle percentages for the current phase.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	// The block's state as the predictor sees it.
	logic        mode_pot;
	int          imu_high, imu_low, pot_high, pot_low;
	int          filtered_pitch;
	int          zero_ref;
	logic        raised;
	longint      movements;

	// Results the block still owes us, oldest first.
	finger_result_t owed_results[$];

	finger_pitch_repetition_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.req_type(req_type),
		.quat_real(quat_real),
		.quat_i(quat_i),
		.quat_j(quat_j),
		.quat_k(quat_k),
		.pot_sample(pot_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.finger_angle(finger_angle),
		.finger_up(finger_up),
		.move_count(move_count),
		.move_done(move_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Integer square root by the classic bit-pair method.
	function automatic longint int_sqrt(longint n);
		longint r = 0;
		longint b = 64'd1 << 30;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Pitch in Q8.8 degrees: arcsine of 2(wj - ki) by CORDIC vectoring.
	function automatic int pitch_of(sample_req_t q);
		longint s, c, x, y, z, dx, dy;
		s = (longint'(q.w) * longint'(q.qj) - longint'(q.qk) * longint'(q.qi)) >>> 13;
		if (s < -16384) s = -16384;
		if (s > 16384) s = 16384;
		c = int_sqrt(64'sd268435456 - s * s);
		x = c * 256;
		y = s * 256;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + ARCTAN_Q16[i];
			end else begin
				x = x - dx; y = y + dy; z = z - ARCTAN_Q16[i];
			end
		end
		z = (z + 128) >>> 8;
		if (z < -fprc_pkg::ANGLE_MAX) z = -fprc_pkg::ANGLE_MAX;
		if (z > fprc_pkg::ANGLE_MAX) z = fprc_pkg::ANGLE_MAX;
		return int'(z);
	endfunction

	// Advances the predictor by one accepted request and returns its result.
	function automatic finger_result_t predict_finger_result(sample_req_t q);
		finger_result_t r;
		longint p, prior, num, quo, rel, ang;
		int hi, lo;
		ang = 0;
		r.done = 1'b0;
		if (q.req == fprc_pkg::REQ_SAMPLE || q.req == fprc_pkg::REQ_ZERO) begin
			if (!mode_pot) begin
				p = pitch_of(q);
				prior = (filtered_pitch == 0) ? p : filtered_pitch;
				num = 2 * (prior + 4 * p) + 5;
				quo = num / 10;
				if ((num % 10) != 0 && num < 0) quo = quo - 1;
				filtered_pitch = int'(quo);
			end
			if (q.req == fprc_pkg::REQ_ZERO)
				zero_ref = mode_pot ? int'(q.pot) : filtered_pitch;
			if (!mode_pot) begin
				rel = longint'(filtered_pitch) - zero_ref;
				ang = (rel < 0) ? 0 : ((rel > fprc_pkg::ANGLE_MAX) ? fprc_pkg::ANGLE_MAX : rel);
			end else begin
				rel = longint'(q.pot) - zero_ref;
				if (rel > 0) begin
					ang = rel * fprc_pkg::ANGLE_MAX / 1023;
					if (ang > fprc_pkg::ANGLE_MAX) ang = fprc_pkg::ANGLE_MAX;
				end
			end
			if (q.req == fprc_pkg::REQ_SAMPLE) begin
				hi = mode_pot ? pot_high : imu_high;
				lo = mode_pot ? pot_low : imu_low;
				if (!raised && ang > hi) begin
					raised = 1'b1;
				end else if (raised && ang < lo) begin
					raised = 1'b0;
					if (movements < COUNT_SAT) movements = movements + 1;
					r.done = 1'b1;
				end
			end
		end else if (q.req == fprc_pkg::REQ_CLEAR) begin
			movements = 0;
			raised = 1'b0;
		end
		r.angle = ang[14:0];
		r.up = raised;
		r.count = movements[15:0];
		return r;
	endfunction

	// The receiver stalls at random as the phase asks.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Compares every accepted result with the oldest prediction.
	always @(posedge clk) begin
		finger_result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result with no request pending: angle %0d up %0d count %0d done %0d",
					$realtime, finger_angle, finger_up, move_count, move_done);
				error_count++;
			end else begin
				e = owed_results.pop_front();
				if (finger_angle !== e.angle) begin
					$display("%0t: finger_angle expected %0d actual %0d",
						$realtime, e.angle, finger_angle);
					error_count++;
				end
				if (finger_up !== e.up) begin
					$display("%0t: finger_up expected %0d actual %0d", $realtime, e.up, finger_up);
					error_count++;
				end
				if (move_count !== e.count) begin
					$display("%0t: move_count expected %0d actual %0d",
						$realtime, e.count, move_count);
					error_count++;
				end
				if (move_done !== e.done) begin
					$display("%0t: move_done expected %0d actual %0d",
						$realtime, e.done, move_done);
					error_count++;
				end
			end
		end
	end

	// The watchdog ends a run in which no handshake completes for too long.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Sends one request. The caller stands at a rising edge; valid stays high
	// after acceptance so that back-to-back requests need no extra toggle.
	task automatic send_request(sample_req_t q);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		req_type <= q.req;
		quat_real <= q.w;
		quat_i <= q.qi;
		quat_j <= q.qj;
		quat_k <= q.qk;
		pot_sample <= q.pot;
		do
			@(posedge clk);
		while (sample_stall);
		owed_results.push_back(predict_finger_result(q));
	endtask

	// Lowers the request line and waits until every result has come back.
	task automatic drain_results();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register writes happen only once the block has gone idle.
	task automatic write_register(logic [2:0] idx, int value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[14:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			fprc_pkg::REG_SENSOR_MODE: mode_pot = value[0];
			fprc_pkg::REG_IMU_HIGH:    imu_high = value & 16'h7FFF;
			fprc_pkg::REG_IMU_LOW:     imu_low = value & 16'h7FFF;
			fprc_pkg::REG_POT_HIGH:    pot_high = value & 16'h7FFF;
			fprc_pkg::REG_POT_LOW:     pot_low = value & 16'h7FFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic sample_req_t make_req(logic [1:0] req, int w, int qi, int qj, int qk,
			int pot);
		sample_req_t q;
		q.req = req;
		q.w = w[15:0];
		q.qi = qi[15:0];
		q.qj = qj[15:0];
		q.qk = qk[15:0];
		q.pot = pot[9:0];
		return q;
	endfunction

	// A quaternion that is a pure rotation about the pitch axis, with a little
	// noise on the other two components.
	function automatic sample_req_t pitch_req(logic [1:0] req, real deg);
		real h;
		h = deg * PI / 360.0;
		return make_req(req, $rtoi($cos(h) * 16384.0), int'($urandom_range(40)) - 20,
			$rtoi($sin(h) * 16384.0), int'($urandom_range(40)) - 20, $urandom_range(1023));
	endfunction

	// Picks a request code for a movement sequence: mostly samples, with the
	// occasional zero capture or clear mixed in.
	function automatic logic [1:0] movement_req();
		int r;
		r = $urandom_range(99);
		if (r < 3) return fprc_pkg::REQ_ZERO;
		if (r < 5) return fprc_pkg::REQ_CLEAR;
		return fprc_pkg::REQ_SAMPLE;
	endfunction

	// Directed: field extremes, every request code, zero capture in both
	// modes, a mode change reading the old zero, and the threshold extremes.
	task automatic test_directed();
		send_request(make_req(fprc_pkg::REQ_SAMPLE, 16384, 0, 0, 0, 0));
		send_request(make_req(fprc_pkg::REQ_SAMPLE, 16384, 16384, 16384, -16384, 1023));
		send_request(make_req(fprc_pkg::REQ_SAMPLE, -16384, 16384, 16384, 16384, 0));
		send_request(make_req(fprc_pkg::REQ_SAMPLE, -32768, -32768, 32767, 32767, 1023));
		send_request(pitch_req(fprc_pkg::REQ_SAMPLE, 85.0));
		send_request(pitch_req(fprc_pkg::REQ_SAMPLE, 2.0));
		send_request(pitch_req(fprc_pkg::REQ_ZERO, 20.0));
		send_request(pitch_req(fprc_pkg::REQ_SAMPLE, 70.0));
		send_request(pitch_req(fprc_pkg::REQ_SAMPLE, -30.0));
		send_request(make_req(fprc_pkg::REQ_UNUSED, 16384, 0, 0, 0, 512));
		send_request(make_req(fprc_pkg::REQ_CLEAR, 0, 0, 0, 0, 0));
		write_register(fprc_pkg::REG_SENSOR_MODE, 1);
		send_request(make_req(fprc_pkg::REQ_SAMPLE, 0, 0, 0, 0, 1023));
		send_request(make_req(fprc_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0));
		send_request(make_req(fprc_pkg::REQ_ZERO, 0, 0, 0, 0, 700));
		send_request(make_req(fprc_pkg::REQ_SAMPLE, 0, 0, 0, 0, 699));
		send_request(make_req(fprc_pkg::REQ_SAMPLE, 0, 0, 0, 0, 1023));
		write_register(fprc_pkg::REG_SENSOR_MODE, 0);
		send_request(pitch_req(fprc_pkg::REQ_SAMPLE, 60.0));
		send_request(make_req(fprc_pkg::REQ_ZERO, 0, 0, 0, 0, 0));
		write_register(fprc_pkg::REG_SENSOR_MODE, 1);
		send_request(make_req(fprc_pkg::REQ_ZERO, 0, 0, 0, 0, 0));
		write_register(fprc_pkg::REG_POT_HIGH, 0);
		write_register(fprc_pkg::REG_POT_LOW, fprc_pkg::ANGLE_MAX);
		send_request(make_req(fprc_pkg::REQ_SAMPLE, 0, 0, 0, 0, 1));
		send_request(make_req(fprc_pkg::REQ_SAMPLE, 0, 0, 0, 0, 1023));
		write_register(fprc_pkg::REG_IMU_HIGH, fprc_pkg::ANGLE_MAX);
		write_register(fprc_pkg::REG_IMU_LOW, 0);
		write_register(fprc_pkg::REG_SENSOR_MODE, 0);
		send_request(pitch_req(fprc_pkg::REQ_SAMPLE, 90.0));
		send_request(pitch_req(fprc_pkg::REQ_SAMPLE, -90.0));
	endtask

	// Threshold settings for one phase: defaults, extremes, then random ones.
	task automatic test_threshold_settings(int phase);
		int lo, hi;
		case (phase)
			0: begin
				write_register(fprc_pkg::REG_IMU_HIGH, 11520);
				write_register(fprc_pkg::REG_IMU_LOW, 2560);
				write_register(fprc_pkg::REG_POT_HIGH, 11520);
				write_register(fprc_pkg::REG_POT_LOW, 2560);
			end
			1: begin
				write_register(fprc_pkg::REG_IMU_HIGH, 0);
				write_register(fprc_pkg::REG_IMU_LOW, 0);
				write_register(fprc_pkg::REG_POT_HIGH, fprc_pkg::ANGLE_MAX);
				write_register(fprc_pkg::REG_POT_LOW, fprc_pkg::ANGLE_MAX);
			end
			default: begin
				lo = $urandom_range(6000);
				hi = lo + $urandom_range(fprc_pkg::ANGLE_MAX - lo);
				write_register(fprc_pkg::REG_IMU_LOW, lo);
				write_register(fprc_pkg::REG_IMU_HIGH, hi);
				lo = $urandom_range(6000);
				hi = lo + $urandom_range(fprc_pkg::ANGLE_MAX - lo);
				write_register(fprc_pkg::REG_POT_LOW, lo);
				write_register(fprc_pkg::REG_POT_HIGH, hi);
			end
		endcase
	endtask

	// IMU movements: pitch sweeps up to a random peak and back down.
	task automatic test_imu_movements(int count);
		real deg, step;
		int dir;
		real peak, trough;
		write_register(fprc_pkg::REG_SENSOR_MODE, 0);
		deg = 0.0;
		dir = 1;
		peak = 40.0 + $urandom_range(55);
		trough = -20.0 + $urandom_range(30);
		for (int n = 0; n < count; n++) begin
			step = 3.0 + $urandom_range(22);
			deg = deg + dir * step;
			if (dir > 0 && deg >= peak) begin
				dir = -1;
				trough = -20.0 + $urandom_range(30);
			end else if (dir < 0 && deg <= trough) begin
				dir = 1;
				peak = 40.0 + $urandom_range(55);
			end
			send_request(pitch_req(movement_req(), deg));
		end
	endtask

	// Potentiometer movements: raw sweeps between a random low and high.
	task automatic test_pot_movements(int count);
		int raw, dir, top, bottom;
		write_register(fprc_pkg::REG_SENSOR_MODE, 1);
		raw = 0;
		dir = 1;
		top = 500 + $urandom_range(523);
		bottom = $urandom_range(150);
		for (int n = 0; n < count; n++) begin
			raw = raw + dir * (20 + int'($urandom_range(180)));
			if (raw > 1023) raw = 1023;
			if (raw < 0) raw = 0;
			if (dir > 0 && raw >= top) begin
				dir = -1;
				bottom = $urandom_range(150);
			end else if (dir < 0 && raw <= bottom) begin
				dir = 1;
				top = 500 + $urandom_range(523);
			end
			send_request(make_req(movement_req(), $urandom, $urandom, $urandom, $urandom, raw));
		end
	endtask

	// Unshaped requests: every field with fully random bits in either mode.
	task automatic test_raw_noise(int count);
		write_register(fprc_pkg::REG_SENSOR_MODE, $urandom_range(1));
		for (int n = 0; n < count; n++)
			send_request(make_req(2'($urandom_range(3)), $urandom, $urandom, $urandom,
				$urandom, $urandom));
	endtask

	initial begin
		mode_pot = 1'b0;
		imu_high = 11520;
		imu_low = 2560;
		pot_high = 11520;
		pot_low = 2560;
		filtered_pitch = 0;
		zero_ref = 0;
		raised = 1'b0;
		movements = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();

		// Phases: no idling, sender idle, receiver stalling, both lightly.
		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			sender_idle_pct = (phase == 1) ? 69 : ((phase == 3) ? 7 : 0);
			receiver_stall_pct = (phase == 2) ? 69 : ((phase == 3) ? 7 : 0);
			test_threshold_settings(phase);
			test_imu_movements(120);
			test_pot_movements(100);
			test_raw_noise(60);
		end

		drain_results();
		repeat (150) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
